@@ src/fpf_pkg.sv @@
// fpf_pkg: shared types and constants of the free-distance pte prefetch filter
// used by fpf_store, fpf_counters and free_pte_prefetch_filter_core
`default_nettype none

package fpf_pkg;

  localparam int NUM_DIST = 14;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 4;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DIST - 1);
  localparam logic [SLOT_W-1:0] POS_SLOT0 = 4'd7;

  localparam logic [CFG_IDX_W-1:0] REG_PROMOTE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 4'd1;

  localparam logic [CFG_W-1:0] PROMOTE_RST = 10'd100;
  localparam logic [CFG_W-1:0] CEILING_RST = 10'd1023;

  typedef enum logic [1:0] {
    OP_WALK      = 2'd0,
    OP_PQ_LOOKUP = 2'd1,
    OP_SM_LOOKUP = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic load;
    logic step;
  } store_ctl_t;

  // slot 0..6 is distance -7..-1, slot 7..13 is +1..+7
  function automatic logic signed [SLOT_W-1:0] dist_of_slot(input logic [SLOT_W-1:0] slot);
    logic signed [SLOT_W-1:0] d;
    if (slot < POS_SLOT0) begin
      d = signed'(slot - 4'd7);
    end else begin
      d = signed'(slot - 4'd6);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/free_pte_prefetch_filter_core.sv @@
// free_pte_prefetch_filter_core: top level, sequencer and scan/insert datapath
// uses fpf_pkg, fpf_store, fpf_counters
//
//   channel   ports                                          handshake
//   input     start, busy, in_opcode, in_virtual_page         start & !busy
//   result    out_valid, out_hit, out_hit_distance,           one-cycle strobe
//             out_queued_mask
//   config    cfg_valid, cfg_ready, cfg_index, cfg_wdata       valid & ready
//
// walk: inserts all 14 neighbours (one neighbour per cycle), then gives the result beat
// lookup: one ram read per cycle from newest entry, until a match or no stored entry is left
// other opcode: goes straight to the result beat; busy is high from accept until the result beat
// reset clears control, counters and fill counts; no clearing pass
// results cannot be stalled
`default_nettype none

module free_pte_prefetch_filter_core #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int SAMPLER_DEPTH = 64,
  parameter int COUNTER_BITS  = 10,
  parameter int PAGE_BITS     = 52
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_opcode,
  input  logic [PAGE_BITS-1:0]             in_virtual_page,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic signed [3:0]                out_hit_distance,
  output logic [fpf_pkg::NUM_DIST-1:0]     out_queued_mask,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpf_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int CW = (COUNTER_BITS > fpf_pkg::CFG_W) ? COUNTER_BITS : fpf_pkg::CFG_W;

  fpf_pkg::state_t state_r, state_nxt;

  logic [fpf_pkg::CFG_W-1:0]  thresh_r;
  logic [fpf_pkg::CFG_W-1:0]  ceil_r;
  logic [PAGE_BITS-1:0]       vp_r;
  logic                       sel_r;
  logic                       pend_r;
  logic                       hit_r;
  logic [fpf_pkg::SLOT_W-1:0] hit_slot_r;
  logic [fpf_pkg::SLOT_W-1:0] walk_slot_r;
  logic [fpf_pkg::NUM_DIST-1:0] mask_r;

  fpf_pkg::store_ctl_t pq_ctl, sm_ctl;
  logic [PAGE_BITS-1:0]       pq_page, sm_page, sel_page, nb_page;
  logic [fpf_pkg::SLOT_W-1:0] pq_slot, sm_slot, sel_slot;
  logic                       pq_more, sm_more, sel_more;
  logic [COUNTER_BITS-1:0]    walk_cnt;
  logic                       promote;
  logic                       match;
  logic                       accept;
  logic                       raise;
  logic signed [fpf_pkg::SLOT_W-1:0] walk_dist;

  assign accept    = start && !busy;
  assign sel_page  = sel_r ? sm_page : pq_page;
  assign sel_slot  = sel_r ? sm_slot : pq_slot;
  assign sel_more  = sel_r ? sm_more : pq_more;
  assign match     = pend_r && (sel_page == vp_r);
  assign promote   = CW'(walk_cnt) > CW'(thresh_r);
  assign walk_dist = fpf_pkg::dist_of_slot(walk_slot_r);
  assign nb_page   = vp_r + {{(PAGE_BITS - fpf_pkg::SLOT_W){walk_dist[fpf_pkg::SLOT_W-1]}},
                             walk_dist};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpf_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_opcode)
            fpf_pkg::OP_WALK:      state_nxt = fpf_pkg::ST_WALK;
            fpf_pkg::OP_PQ_LOOKUP: state_nxt = fpf_pkg::ST_SCAN;
            fpf_pkg::OP_SM_LOOKUP: state_nxt = fpf_pkg::ST_SCAN;
            default:               state_nxt = fpf_pkg::ST_DONE;
          endcase
        end
      end
      fpf_pkg::ST_WALK: begin
        if (walk_slot_r == fpf_pkg::LAST_SLOT) begin
          state_nxt = fpf_pkg::ST_DONE;
        end
      end
      fpf_pkg::ST_SCAN: begin
        if (match || !sel_more) begin
          state_nxt = fpf_pkg::ST_DONE;
        end
      end
      fpf_pkg::ST_DONE: state_nxt = fpf_pkg::ST_IDLE;
      default:          state_nxt = fpf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pq_ctl    = '0;
    sm_ctl    = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    raise     = 1'b0;
    unique case (state_r)
      fpf_pkg::ST_IDLE: begin
        busy        = 1'b0;
        pq_ctl.load = start;
        sm_ctl.load = start;
      end
      fpf_pkg::ST_WALK: begin
        pq_ctl.push = promote;
        sm_ctl.push = !promote;
      end
      fpf_pkg::ST_SCAN: begin
        pq_ctl.step = !sel_r && !match;
        sm_ctl.step = sel_r && !match;
      end
      fpf_pkg::ST_DONE: begin
        out_valid = 1'b1;
        raise     = hit_r;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fpf_pkg::ST_IDLE;
      thresh_r <= fpf_pkg::PROMOTE_RST;
      ceil_r   <= fpf_pkg::CEILING_RST;
      pend_r   <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fpf_pkg::REG_PROMOTE: thresh_r <= cfg_wdata;
          fpf_pkg::REG_CEILING: ceil_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (state_r == fpf_pkg::ST_SCAN) begin
        pend_r <= sel_more && !match;
        if (match) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vp_r        <= in_virtual_page;
      sel_r       <= (in_opcode == fpf_pkg::OP_SM_LOOKUP);
      walk_slot_r <= '0;
      mask_r      <= '0;
      hit_slot_r  <= '0;
    end else if (state_r == fpf_pkg::ST_WALK) begin
      walk_slot_r         <= walk_slot_r + 1'b1;
      mask_r[walk_slot_r] <= promote;
    end else if ((state_r == fpf_pkg::ST_SCAN) && match) begin
      hit_slot_r <= sel_slot;
    end
  end

  fpf_store #(
    .DEPTH     (QUEUE_DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_pq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (pq_ctl),
    .wr_page (nb_page),
    .wr_slot (walk_slot_r),
    .rd_page (pq_page),
    .rd_slot (pq_slot),
    .more    (pq_more)
  );

  fpf_store #(
    .DEPTH     (SAMPLER_DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_sm (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sm_ctl),
    .wr_page (nb_page),
    .wr_slot (walk_slot_r),
    .rd_page (sm_page),
    .rd_slot (sm_slot),
    .more    (sm_more)
  );

  fpf_counters #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .raise      (raise),
    .raise_slot (hit_slot_r),
    .ceiling    (ceil_r),
    .rd_slot    (walk_slot_r),
    .rd_value   (walk_cnt)
  );

  assign cfg_ready        = 1'b1;
  assign out_hit          = hit_r;
  assign out_hit_distance = hit_r ? fpf_pkg::dist_of_slot(hit_slot_r) : 4'sd0;
  assign out_queued_mask  = mask_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_hit_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_queued_mask == '0))
    else $error("lookup hit carries a queued mask");

  a_miss_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_distance == 4'sd0))
    else $error("miss carries a distance");

  a_hit_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_distance != 4'sd0))
    else $error("hit with zero distance");
`endif

endmodule

`default_nettype wire

@@ src/fpf_ram.sv @@
// fpf_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module fpf_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ src/fpf_store.sv @@
// fpf_store: page/distance ring that drops its oldest entry when full,
// with a newest-to-oldest scan pointer; uses fpf_pkg and fpf_ram
`default_nettype none

module fpf_store #(
  parameter int DEPTH     = 64,
  parameter int PAGE_BITS = 52
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpf_pkg::store_ctl_t       ctl,
  input  logic [PAGE_BITS-1:0]      wr_page,
  input  logic [fpf_pkg::SLOT_W-1:0] wr_slot,
  output logic [PAGE_BITS-1:0]      rd_page,
  output logic [fpf_pkg::SLOT_W-1:0] rd_slot,
  output logic                      more
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int EW   = PAGE_BITS + fpf_pkg::SLOT_W;
  localparam logic [AW-1:0]   LAST = AW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL = CNTW'(DEPTH);

  logic [AW-1:0]   head_r, head_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [CNTW-1:0] left_r, left_nxt;
  logic [EW-1:0]   rd_data;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    if (ctl.push) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
      if (count_r != FULL) begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (ctl.load) begin
      pos_nxt  = (head_r == '0) ? LAST : head_r - 1'b1;
      left_nxt = count_r;
    end else if (ctl.step && more) begin
      pos_nxt  = (pos_r == '0) ? LAST : pos_r - 1'b1;
      left_nxt = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      pos_r   <= '0;
      left_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
    end
  end

  fpf_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (head_r),
    .wr_data ({wr_page, wr_slot}),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign rd_page = rd_data[EW-1:fpf_pkg::SLOT_W];
  assign rd_slot = rd_data[fpf_pkg::SLOT_W-1:0];
  assign more    = (left_r != '0);

endmodule

`default_nettype wire

@@ src/fpf_counters.sv @@
// fpf_counters: the 14 saturating distance counters with halving on ceiling
// uses fpf_pkg
`default_nettype none

module fpf_counters #(
  parameter int COUNTER_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          raise,
  input  logic [fpf_pkg::SLOT_W-1:0]    raise_slot,
  input  logic [fpf_pkg::CFG_W-1:0]     ceiling,
  input  logic [fpf_pkg::SLOT_W-1:0]    rd_slot,
  output logic [COUNTER_BITS-1:0]       rd_value
);

  localparam int CW = (COUNTER_BITS > fpf_pkg::CFG_W) ? COUNTER_BITS : fpf_pkg::CFG_W;
  localparam logic [CW-1:0] CMAX = CW'((64'd1 << COUNTER_BITS) - 64'd1);

  logic [COUNTER_BITS-1:0] cnt_r   [fpf_pkg::NUM_DIST];
  logic [COUNTER_BITS-1:0] cnt_nxt [fpf_pkg::NUM_DIST];
  logic [CW-1:0]           ceil_eff;
  logic [CW-1:0]           cur;
  logic [CW-1:0]           inc;
  logic                    slot_ok;
  logic                    bump;
  logic                    halve;

  assign ceil_eff = (CW'(ceiling) > CMAX) ? CMAX : CW'(ceiling);
  assign slot_ok  = (raise_slot <= fpf_pkg::LAST_SLOT);
  assign cur      = slot_ok ? CW'(cnt_r[raise_slot]) : '0;
  assign inc      = cur + 1'b1;
  assign bump     = raise && slot_ok && (cur < ceil_eff);
  assign halve    = bump && (inc == ceil_eff);

  always_comb begin
    for (int i = 0; i < fpf_pkg::NUM_DIST; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (bump && (raise_slot == fpf_pkg::SLOT_W'(i))) begin
        cnt_nxt[i] = halve ? COUNTER_BITS'(inc >> 1) : COUNTER_BITS'(inc);
      end else if (halve) begin
        cnt_nxt[i] = cnt_r[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fpf_pkg::NUM_DIST; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < fpf_pkg::NUM_DIST; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign rd_value = (rd_slot <= fpf_pkg::LAST_SLOT) ? cnt_r[rd_slot] : '0;

endmodule

`default_nettype wire
